### rtl/pwcs_pkg.sv
// ----------------------------------------------------------------------------
// pwcs_pkg: shared types and constants of the pulse-width command sender
// Phase codes, item kinds, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pwcs_pkg;

    // Number of command bits sent per frame, LSB first.
    localparam int COMMAND_BITS = 8;
    localparam int BIT_CNT_W    = $clog2(COMMAND_BITS + 1);

    localparam int DUR_W     = 8;
    localparam int CMD_W     = 8;
    localparam int KIND_W    = 2;
    localparam int PHASE_W   = 3;
    localparam int CFG_IDX_W = 3;

    // Item kinds carried on tuser.
    localparam logic [KIND_W-1:0] KIND_TICK      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEND      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEND_WAIT = 2'd2;

    // Phase codes of the frame sequencer.
    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_BITHI    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BITLO    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_STOP     = 3'd4;
    localparam logic [PHASE_W-1:0] PH_WAITBUSY = 3'd5;
    localparam logic [PHASE_W-1:0] PH_HOLD     = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUSY_HOLD = 3'd4;

    // Reset values of the duration registers, in ticks.
    localparam logic [DUR_W-1:0] RST_START_LOW = 8'd25;
    localparam logic [DUR_W-1:0] RST_SHORT     = 8'd1;
    localparam logic [DUR_W-1:0] RST_LONG      = 8'd3;
    localparam logic [DUR_W-1:0] RST_STOP_HIGH = 8'd100;
    localparam logic [DUR_W-1:0] RST_BUSY_HOLD = 8'd200;

    typedef struct packed {
        logic [DUR_W-1:0] start_low_ticks;
        logic [DUR_W-1:0] short_ticks;
        logic [DUR_W-1:0] long_ticks;
        logic [DUR_W-1:0] stop_high_ticks;
        logic [DUR_W-1:0] busy_hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic data_line;
        logic idle;
        logic rejected;
    } result_t;

endpackage

`default_nettype wire

### rtl/pwcs_cfg_regs.sv
// ----------------------------------------------------------------------------
// pwcs_cfg_regs: duration registers
// Five write-only duration registers loaded through a simple write port.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcs_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pwcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pwcs_pkg::DUR_W-1:0]      cfg_wdata,
    output pwcs_pkg::cfg_t                       cfg
);

    pwcs_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks <= pwcs_pkg::RST_START_LOW;
            cfg_reg.short_ticks     <= pwcs_pkg::RST_SHORT;
            cfg_reg.long_ticks      <= pwcs_pkg::RST_LONG;
            cfg_reg.stop_high_ticks <= pwcs_pkg::RST_STOP_HIGH;
            cfg_reg.busy_hold_ticks <= pwcs_pkg::RST_BUSY_HOLD;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pwcs_pkg::REG_START_LOW: cfg_reg.start_low_ticks <= cfg_wdata;
                pwcs_pkg::REG_SHORT:     cfg_reg.short_ticks     <= cfg_wdata;
                pwcs_pkg::REG_LONG:      cfg_reg.long_ticks      <= cfg_wdata;
                pwcs_pkg::REG_STOP_HIGH: cfg_reg.stop_high_ticks <= cfg_wdata;
                pwcs_pkg::REG_BUSY_HOLD: cfg_reg.busy_hold_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/pwcs_core.sv
// ----------------------------------------------------------------------------
// pwcs_core: frame sequencer
// Holds the phase, tick timer and shift state and advances them by one word.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcs_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic [pwcs_pkg::KIND_W-1:0]    kind,
    input  wire logic [pwcs_pkg::CMD_W-1:0]     command,
    input  wire logic                           busy_req,
    input  wire pwcs_pkg::cfg_t                 cfg,
    output pwcs_pkg::result_t                   result
);

    logic [pwcs_pkg::PHASE_W-1:0]      phase_reg, phase_next;
    logic [pwcs_pkg::DUR_W-1:0]        timer_reg, timer_next;
    logic [pwcs_pkg::BIT_CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [pwcs_pkg::COMMAND_BITS-1:0] shift_reg, shift_next;
    logic                              wait_after_reg, wait_after_next;
    logic                              line_reg, line_next;
    logic                              rejected;
    logic [pwcs_pkg::COMMAND_BITS-1:0] shifted;
    logic                              last_bit;

    assign shifted  = shift_reg >> 1;
    assign last_bit = (bit_cnt_reg ==
                       pwcs_pkg::BIT_CNT_W'(pwcs_pkg::COMMAND_BITS - 1));

    always_comb
    begin
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        wait_after_next = wait_after_reg;
        line_next       = line_reg;
        rejected        = 1'b0;

        if (kind == pwcs_pkg::KIND_TICK)
        begin
            if (phase_reg == pwcs_pkg::PH_WAITBUSY)
            begin
                // The hold timer is loaded here and starts counting next tick.
                if (!busy_req)
                begin
                    phase_next = pwcs_pkg::PH_HOLD;
                    timer_next = cfg.busy_hold_ticks;
                end
            end
            else if (phase_reg != pwcs_pkg::PH_IDLE)
            begin
                // A timer value of zero or one ends the phase on this tick.
                if (timer_reg <= pwcs_pkg::DUR_W'(1))
                begin
                    unique case (phase_reg)
                        pwcs_pkg::PH_START:
                        begin
                            phase_next = pwcs_pkg::PH_BITHI;
                            line_next  = 1'b1;
                            timer_next = shift_reg[0] ? cfg.long_ticks : cfg.short_ticks;
                        end
                        pwcs_pkg::PH_BITHI:
                        begin
                            phase_next = pwcs_pkg::PH_BITLO;
                            line_next  = 1'b0;
                            timer_next = shift_reg[0] ? cfg.short_ticks : cfg.long_ticks;
                        end
                        pwcs_pkg::PH_BITLO:
                        begin
                            shift_next   = shifted;
                            bit_cnt_next = bit_cnt_reg + pwcs_pkg::BIT_CNT_W'(1);
                            line_next    = 1'b1;
                            if (last_bit)
                            begin
                                phase_next = pwcs_pkg::PH_STOP;
                                timer_next = cfg.stop_high_ticks;
                            end
                            else
                            begin
                                phase_next = pwcs_pkg::PH_BITHI;
                                timer_next = shifted[0] ? cfg.long_ticks : cfg.short_ticks;
                            end
                        end
                        pwcs_pkg::PH_STOP:
                        begin
                            phase_next = wait_after_reg ? pwcs_pkg::PH_WAITBUSY
                                                        : pwcs_pkg::PH_IDLE;
                            timer_next = '0;
                        end
                        pwcs_pkg::PH_HOLD:
                        begin
                            phase_next = pwcs_pkg::PH_IDLE;
                            timer_next = '0;
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    timer_next = timer_reg - pwcs_pkg::DUR_W'(1);
                end
            end
        end
        else if (kind == pwcs_pkg::KIND_SEND || kind == pwcs_pkg::KIND_SEND_WAIT)
        begin
            if (phase_reg != pwcs_pkg::PH_IDLE)
            begin
                rejected = 1'b1;
            end
            else
            begin
                shift_next      = pwcs_pkg::COMMAND_BITS'(command);
                bit_cnt_next    = '0;
                wait_after_next = (kind == pwcs_pkg::KIND_SEND_WAIT);
                phase_next      = pwcs_pkg::PH_START;
                line_next       = 1'b0;
                timer_next      = cfg.start_low_ticks;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= pwcs_pkg::PH_IDLE;
            timer_reg      <= '0;
            bit_cnt_reg    <= '0;
            shift_reg      <= '0;
            wait_after_reg <= 1'b0;
            line_reg       <= 1'b1;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            timer_reg      <= timer_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            wait_after_reg <= wait_after_next;
            line_reg       <= line_next;
        end
    end

    assign result.data_line = line_next;
    assign result.idle      = (phase_next == pwcs_pkg::PH_IDLE);
    assign result.rejected  = rejected;

endmodule

`default_nettype wire

### rtl/pulse_width_command_sender.sv
// ----------------------------------------------------------------------------
// pulse_width_command_sender: single-wire pulse-width command transmitter
// Input register, frame sequencer and result register.
// ----------------------------------------------------------------------------
// Each input word is a tick, a send, or a send followed by a busy wait,
// chosen by s_axis_tuser. The sequencer walks through start low, the
// command bits LSB first (one: long high, short low; zero: short high,
// long low), stop high and, for a send with wait, the busy poll and hold.
// Every accepted word yields exactly one result word carrying the line
// level after that word, the idle flag and a reject flag for a send that
// arrived mid-frame. Durations count tick words and come from five
// registers written through cfg_wr_en, cfg_index and cfg_wdata. The user
// must write them only while idle; the block does not enforce it. A word
// lands in the input register when accepted, and its result then enters the
// result register. Throughput is one word per cycle unless the receiver
// stalls; the phase update is a single pass of the sequencer logic. When
// the receiver stalls, the result register holds, one more word may wait in
// the input register, and then s_axis_tready drops. Reset empties both
// registers, loads the register defaults and leaves the line high and idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_width_command_sender (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [15:0]                     s_axis_tdata,  // command[7:0], busy_req[8]
    input  wire logic [1:0]                      s_axis_tuser,  // kind[1:0]
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // data_line, idle, rejected
    input  wire logic                            cfg_wr_en,
    input  wire logic [pwcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pwcs_pkg::DUR_W-1:0]      cfg_wdata
);

    logic                          in_valid_reg;
    logic [pwcs_pkg::KIND_W-1:0]   in_kind_reg;
    logic [pwcs_pkg::CMD_W-1:0]    in_cmd_reg;
    logic                          in_busy_reg;
    logic                          out_valid_reg;
    pwcs_pkg::result_t             out_reg;
    pwcs_pkg::result_t             result;
    pwcs_pkg::cfg_t                cfg;
    logic                          step;
    logic                          in_take;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_take || (in_valid_reg && !step);
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_kind_reg <= s_axis_tuser;
            in_cmd_reg  <= s_axis_tdata[7:0];
            in_busy_reg <= s_axis_tdata[8];
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    pwcs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pwcs_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .kind     (in_kind_reg),
        .command  (in_cmd_reg),
        .busy_req (in_busy_reg),
        .cfg      (cfg),
        .result   (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg.rejected, out_reg.idle, out_reg.data_line};

endmodule

`default_nettype wire

### rtl/pwcs_checker.sv
// ----------------------------------------------------------------------------
// pwcs_checker: port-level checks of the pulse-width command sender
// Watches the result stream and flags words that no correct state allows.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcs_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata
);

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // A send is rejected only mid-frame, so the block cannot report idle with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1])
        else $error("rejected word reports idle");

    // The line is always released high while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("line low while idle");

    // A result needs an accepted word: a new one cannot appear unless a word
    // was accepted before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tvalid && s_axis_tready) ##1 !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result word without an accepted input word");

    // Pad bits of the result word stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:3] == 5'b0)
        else $error("result pad bits set");

endmodule

bind pulse_width_command_sender pwcs_checker u_pwcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
